/* rtl/windowed_rms_current_meter_unit_macros.svh */
// assertion macros for the windowed rms current meter
// used by the port checker; no other dependencies
`ifndef WINDOWED_RMS_CURRENT_METER_UNIT_MACROS_SVH
`define WINDOWED_RMS_CURRENT_METER_UNIT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define WRCM_ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent at one edge implies consequent at the next edge
`define WRCM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/wrcm_pkg.sv */
// shared types and constants of the windowed rms current meter
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package wrcm_pkg;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_SQRT,
		ST_DONE
	} state_t;

	// request command codes
	localparam logic CmdSample = 1'b0;
	localparam logic CmdTick   = 1'b1;

	localparam int unsigned SumW      = 42;
	localparam int unsigned CountW    = 12;
	localparam int unsigned SampleW   = 16;
	localparam int unsigned TickW     = 16;
	localparam int unsigned RemW      = CountW + 1;
	localparam int unsigned StepW     = 6;
	localparam int unsigned DivSteps  = SumW;
	localparam int unsigned SqrtSteps = SumW / 2;

	localparam int unsigned MaxSamples = 4095;
	localparam int unsigned CountMax   = (1 << CountW) - 1;
	localparam logic [CountW-1:0] CountLimit =
		CountW'(MaxSamples > CountMax ? CountMax : MaxSamples);

	localparam logic [TickW-1:0] WindowTicksReset = 16'd100;
	localparam logic [SumW-1:0]  SqrtBitInit      = SumW'(1) << (SumW - 2);

endpackage

`default_nettype wire

/* rtl/wrcm_if.sv */
// request and result channels of the windowed rms current meter
// depends on wrcm_pkg
`timescale 1ns / 1ps
`default_nettype none

interface wrcm_sample_if;
	logic                                 valid;
	logic                                 ready;
	logic                                 command;
	logic signed [wrcm_pkg::SampleW-1:0]  current_sample;
	logic                                 read_error;

	modport source (output valid, command, current_sample, read_error, input ready);
	modport sink (input valid, command, current_sample, read_error, output ready);
endinterface

interface wrcm_result_if;
	logic                          valid;
	logic                          ready;
	logic [wrcm_pkg::SampleW-1:0]  rms_value;
	logic [wrcm_pkg::CountW-1:0]   window_samples;
	logic                          window_done;

	modport source (output valid, rms_value, window_samples, window_done, input ready);
	modport sink (input valid, rms_value, window_samples, window_done, output ready);
endinterface

`default_nettype wire

/* rtl/wrcm_alu.sv */
// shared add / subtract unit of the windowed rms current meter
// depends on wrcm_pkg
`timescale 1ns / 1ps
`default_nettype none

module wrcm_alu (
	input  wire logic [wrcm_pkg::SumW-1:0] a,
	input  wire logic [wrcm_pkg::SumW-1:0] b,
	input  wire logic                      sub,
	output logic      [wrcm_pkg::SumW-1:0] res,
	output logic                           carry
);

	logic [wrcm_pkg::SumW-1:0] b_eff;

	assign b_eff = sub ? ~b : b;

	// on subtract, carry set means a >= b
	assign {carry, res} = {1'b0, a} + {1'b0, b_eff} + (wrcm_pkg::SumW+1)'(sub);

endmodule

`default_nettype wire

/* rtl/windowed_rms_current_meter_unit.sv */
// windowed rms current meter, top level
// depends on wrcm_pkg, wrcm_if and wrcm_alu
`timescale 1ns / 1ps
`default_nettype none

// usage
// - sample_in carries one request: a current sample (command 0) or a
//   millisecond tick (command 1); a request is taken when valid and ready
//   are both high
// - result_out gives exactly one result per request: the rms and good
//   sample count of the latest closed window, and window_done when this
//   request closed a window
// - cfg_wr_en / cfg_wr_data write the window length in ticks; 0 acts as 1
// - one request is worked on at a time; ready is high only while the
//   sequencer is idle
// - a tick that does not close a window, or a dropped sample, goes straight
//   to the final state; a good sample takes one shift-add step per significant
//   bit of its magnitude, at least one; a tick that closes a non-empty
//   window runs 42 restoring divide steps, then 21 square root
//   steps, all on the one shared add / subtract unit
// - a result sits in an output register; the next request can be taken
//   while it waits, and the sequencer holds in its final state only if a
//   new result is ready while the old one has not been taken
// - reset clears the sum, count, timer and last window values and sets
//   the window length to 100 ticks
module windowed_rms_current_meter_unit (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	wrcm_sample_if.sink                      sample_in,
	wrcm_result_if.source                    result_out,
	input  wire logic                        cfg_wr_en,
	input  wire logic [wrcm_pkg::TickW-1:0]  cfg_wr_data
);

	localparam int unsigned SumW   = wrcm_pkg::SumW;
	localparam int unsigned CountW = wrcm_pkg::CountW;
	localparam int unsigned TickW  = wrcm_pkg::TickW;
	localparam int unsigned RemW   = wrcm_pkg::RemW;
	localparam int unsigned StepW  = wrcm_pkg::StepW;
	localparam int unsigned SampW  = wrcm_pkg::SampleW;

	wrcm_pkg::state_t state_q, state_d;

	// running window state
	logic [SumW-1:0]   acc_q;          // square sum, then dividend/quotient, then radicand
	logic [CountW-1:0] cnt_q;
	logic [TickW-1:0]  tick_q;
	logic [TickW-1:0]  window_ticks_q;
	logic [SampW-1:0]  last_rms_q;
	logic [CountW-1:0] last_samples_q;
	logic              done_q;

	// sequencer work registers
	logic [SumW-1:0]   opa_q;          // shifted multiplicand, then root
	logic [SampW-1:0]  mq_q;           // multiplier bits
	logic [RemW-1:0]   rem_q;          // divide remainder
	logic [SumW-1:0]   bit_q;          // root trial bit
	logic [StepW-1:0]  step_q;

	// output register
	logic              out_valid_q;
	logic [SampW-1:0]  out_rms_q;
	logic [CountW-1:0] out_samples_q;
	logic              out_done_q;

	logic              accept;
	logic              out_load;
	logic [SampW-1:0]  raw;
	logic [SampW-1:0]  mag;
	logic              take_sample;
	logic [TickW-1:0]  win_len;
	logic [TickW-1:0]  tick_nxt;
	logic              close_win;
	logic [RemW-1:0]   rem_sh;
	logic [SumW-1:0]   root_nxt;

	logic [SumW-1:0]   alu_a;
	logic [SumW-1:0]   alu_b;
	logic              alu_sub;
	logic [SumW-1:0]   alu_res;
	logic              alu_carry;

	assign sample_in.ready = (state_q == wrcm_pkg::ST_IDLE);
	assign accept          = sample_in.valid && sample_in.ready;

	// result register is free, or is being emptied this cycle
	assign out_load = (state_q == wrcm_pkg::ST_DONE) && (!out_valid_q || result_out.ready);

	// magnitude of the two's complement reading; the most negative one maps to 32768
	assign raw         = sample_in.current_sample;
	assign mag         = raw[SampW-1] ? (~raw + SampW'(1)) : raw;
	assign take_sample = !sample_in.read_error && (cnt_q < wrcm_pkg::CountLimit);

	// timer saturates, zero window length acts as one tick
	assign win_len   = (window_ticks_q == '0) ? TickW'(1) : window_ticks_q;
	assign tick_nxt  = (tick_q == '1) ? tick_q : tick_q + TickW'(1);
	assign close_win = (tick_nxt >= win_len);

	// next partial remainder brings in the top dividend bit
	assign rem_sh = {rem_q[RemW-2:0], acc_q[SumW-1]};

	// root update; trial bit never overlaps the shifted root
	assign root_nxt = alu_carry ? ((opa_q >> 1) | bit_q) : (opa_q >> 1);

	// operand steering for the shared unit
	always_comb begin
		alu_a   = acc_q;
		alu_b   = opa_q;
		alu_sub = 1'b0;
		unique case (state_q)
			wrcm_pkg::ST_MUL: begin
				alu_a   = acc_q;
				alu_b   = opa_q;
				alu_sub = 1'b0;
			end
			wrcm_pkg::ST_DIV: begin
				alu_a   = SumW'(rem_sh);
				alu_b   = SumW'(cnt_q);
				alu_sub = 1'b1;
			end
			wrcm_pkg::ST_SQRT: begin
				alu_a   = acc_q;
				alu_b   = opa_q | bit_q;
				alu_sub = 1'b1;
			end
			wrcm_pkg::ST_IDLE, wrcm_pkg::ST_DONE: begin
				alu_a   = acc_q;
				alu_b   = opa_q;
				alu_sub = 1'b0;
			end
			default: begin
				alu_a   = acc_q;
				alu_b   = opa_q;
				alu_sub = 1'b0;
			end
		endcase
	end

	wrcm_alu u_alu (
		.a     (alu_a),
		.b     (alu_b),
		.sub   (alu_sub),
		.res   (alu_res),
		.carry (alu_carry)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			wrcm_pkg::ST_IDLE: begin
				if (accept) begin
					if (sample_in.command == wrcm_pkg::CmdSample) begin
						state_d = take_sample ? wrcm_pkg::ST_MUL : wrcm_pkg::ST_DONE;
					end else if (close_win && (cnt_q != '0)) begin
						state_d = wrcm_pkg::ST_DIV;
					end else begin
						state_d = wrcm_pkg::ST_DONE;
					end
				end
			end
			wrcm_pkg::ST_MUL: begin
				if (mq_q[SampW-1:1] == '0) begin
					state_d = wrcm_pkg::ST_DONE;
				end
			end
			wrcm_pkg::ST_DIV: begin
				if (step_q == StepW'(wrcm_pkg::DivSteps - 1)) begin
					state_d = wrcm_pkg::ST_SQRT;
				end
			end
			wrcm_pkg::ST_SQRT: begin
				if (step_q == StepW'(wrcm_pkg::SqrtSteps - 1)) begin
					state_d = wrcm_pkg::ST_DONE;
				end
			end
			wrcm_pkg::ST_DONE: begin
				if (out_load) begin
					state_d = wrcm_pkg::ST_IDLE;
				end
			end
			default: state_d = wrcm_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wrcm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_ticks_q <= wrcm_pkg::WindowTicksReset;
		end else if (cfg_wr_en) begin
			window_ticks_q <= cfg_wr_data;
		end
	end

	// window state and sequencer datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q          <= '0;
			cnt_q          <= '0;
			tick_q         <= '0;
			last_rms_q     <= '0;
			last_samples_q <= '0;
			done_q         <= 1'b0;
		end else begin
			unique case (state_q)
				wrcm_pkg::ST_IDLE: begin
					if (accept) begin
						if (sample_in.command == wrcm_pkg::CmdSample) begin
							done_q <= 1'b0;
							if (take_sample) begin
								cnt_q <= cnt_q + CountW'(1);
							end
						end else begin
							done_q <= close_win;
							tick_q <= close_win ? '0 : tick_nxt;
							if (close_win) begin
								last_samples_q <= cnt_q;
								if (cnt_q == '0) begin
									last_rms_q <= '0;
									acc_q      <= '0;
								end
							end
						end
					end
				end
				wrcm_pkg::ST_MUL: begin
					// sum cannot overflow while the count stays within 12 bits
					if (mq_q[0]) begin
						acc_q <= alu_res;
					end
				end
				wrcm_pkg::ST_DIV: begin
					acc_q <= {acc_q[SumW-2:0], alu_carry};
				end
				wrcm_pkg::ST_SQRT: begin
					if (step_q == StepW'(wrcm_pkg::SqrtSteps - 1)) begin
						last_rms_q <= root_nxt[SampW-1:0];
						acc_q      <= '0;
						cnt_q      <= '0;
					end else if (alu_carry) begin
						acc_q <= alu_res;
					end
				end
				wrcm_pkg::ST_DONE: begin
				end
				default: begin
				end
			endcase
		end
	end

	// work registers, loaded on entry to each phase
	always_ff @(posedge clk) begin
		unique case (state_q)
			wrcm_pkg::ST_IDLE: begin
				opa_q  <= SumW'(mag);
				mq_q   <= mag;
				rem_q  <= '0;
				step_q <= '0;
			end
			wrcm_pkg::ST_MUL: begin
				opa_q <= opa_q << 1;
				mq_q  <= mq_q >> 1;
			end
			wrcm_pkg::ST_DIV: begin
				rem_q <= alu_carry ? alu_res[RemW-1:0] : rem_sh;
				if (step_q == StepW'(wrcm_pkg::DivSteps - 1)) begin
					opa_q  <= '0;
					bit_q  <= wrcm_pkg::SqrtBitInit;
					step_q <= '0;
				end else begin
					step_q <= step_q + StepW'(1);
				end
			end
			wrcm_pkg::ST_SQRT: begin
				opa_q  <= root_nxt;
				bit_q  <= bit_q >> 2;
				step_q <= step_q + StepW'(1);
			end
			wrcm_pkg::ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_rms_q     <= last_rms_q;
			out_samples_q <= last_samples_q;
			out_done_q    <= done_q;
		end
	end

	assign result_out.valid          = out_valid_q;
	assign result_out.rms_value      = out_rms_q;
	assign result_out.window_samples = out_samples_q;
	assign result_out.window_done    = out_done_q;

endmodule

`default_nettype wire

/* rtl/wrcm_checker.sv */
// port checker for the windowed rms current meter, bound to the top level
// depends on wrcm_pkg and windowed_rms_current_meter_unit_macros.svh
`timescale 1ns / 1ps
`default_nettype none

`include "windowed_rms_current_meter_unit_macros.svh"

module wrcm_checker (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           in_valid,
	input wire logic                           in_ready,
	input wire logic                           out_valid,
	input wire logic                           out_ready,
	input wire logic [wrcm_pkg::SampleW-1:0]   rms_value,
	input wire logic [wrcm_pkg::CountW-1:0]    window_samples,
	input wire logic                           window_done
);

	// one request at a time: ready drops right after a request
	`WRCM_ASSERT_NEXT(a_busy_after_req, clk, arst_n, in_valid && in_ready, !in_ready, "ready held after request")

	// a stalled result holds
	`WRCM_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(rms_value) && $stable(window_samples) && $stable(window_done), "stalled result changed")

	// an empty window reports a zero rms
	`WRCM_ASSERT_ALWAYS(a_empty_zero, clk, arst_n, !out_valid || (window_samples != '0) || (rms_value == '0), "empty window with nonzero rms")

	// rms of a 16-bit reading never exceeds full scale
	`WRCM_ASSERT_ALWAYS(a_rms_range, clk, arst_n, !out_valid || (rms_value <= 16'd32768), "rms out of range")

endmodule

bind windowed_rms_current_meter_unit wrcm_checker u_wrcm_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (sample_in.valid),
	.in_ready       (sample_in.ready),
	.out_valid      (result_out.valid),
	.out_ready      (result_out.ready),
	.rms_value      (result_out.rms_value),
	.window_samples (result_out.window_samples),
	.window_done    (result_out.window_done)
);

`default_nettype wire

/* tb/sv/windowed_rms_current_meter_unit_tb.sv */
// testbench for windowed_rms_current_meter_unit: random and directed requests,
// checked result by result against a cycle-free model of the meter
// depends on wrcm_pkg, wrcm_if and the rtl top level
`timescale 1ns / 1ps

module windowed_rms_current_meter_unit_tb;

	localparam int unsigned ClkHalf      = 6;
	localparam int unsigned ResetCycles  = 12;
	localparam int unsigned IdlePct      = 20;
	localparam int unsigned SettleCycles = 80;
	// timeout guard limit, set many times over the length of a slow run
	localparam longint unsigned CycleLimit = 2_000_000;
	localparam logic [63:0] SumCeil = (64'd1 << wrcm_pkg::SumW) - 64'd1;

	// one request on the sample channel
	typedef struct packed {
		logic                                command;
		logic signed [wrcm_pkg::SampleW-1:0] current_sample;
		logic                                read_error;
	} meter_req_t;

	// one result on the result channel
	typedef struct packed {
		logic [wrcm_pkg::SampleW-1:0] rms_value;
		logic [wrcm_pkg::CountW-1:0]  window_samples;
		logic                         window_done;
	} meter_reading_t;

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_wr_en;
	logic [wrcm_pkg::TickW-1:0] cfg_wr_data;

	wrcm_sample_if sample_in ();
	wrcm_result_if result_out ();

	windowed_rms_current_meter_unit u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample_in   (sample_in),
		.result_out  (result_out),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	// requests waiting for the driver, and readings the meter still owes us
	meter_req_t     pending_reqs[$];
	meter_reading_t expected_readings[$];

	int unsigned     reqs_queued;
	int unsigned     reqs_taken;
	int unsigned     fail_cnt;
	longint unsigned cycle_cnt;
	logic            req_accepted;
	// set during the long stretch where neither side idles
	logic            steady;

	// model state of the meter
	logic [wrcm_pkg::TickW-1:0]   win_len;
	logic [wrcm_pkg::SumW-1:0]    sq_sum;
	logic [wrcm_pkg::CountW-1:0]  good_cnt;
	logic [wrcm_pkg::TickW-1:0]   tick_cnt;
	logic [wrcm_pkg::SampleW-1:0] held_rms;
	logic [wrcm_pkg::CountW-1:0]  held_cnt;

	// clock, low phase first
	initial clk = 1'b0;
	always begin
		#(ClkHalf) clk = 1'b1;
		#(ClkHalf) clk = 1'b0;
	end

	// truncated square root, built up one result bit at a time from the top
	function automatic logic [wrcm_pkg::SampleW-1:0] int_sqrt(input logic [63:0] v);
		logic [63:0] root;
		logic [63:0] trial;
		root = '0;
		for (int i = 21; i >= 0; i--) begin
			trial = root | (64'd1 << i);
			if (trial * trial <= v)
				root = trial;
		end
		return root[wrcm_pkg::SampleW-1:0];
	endfunction

	// advance the meter model by one request and give the reading it must produce
	task automatic rms_meter_step(input meter_req_t req, output meter_reading_t rd);
		logic [16:0]                mag;
		logic [63:0]                sq;
		logic [63:0]                sum_wide;
		logic [wrcm_pkg::TickW-1:0] len;
		rd.window_done = 1'b0;
		if (req.command == wrcm_pkg::CmdSample) begin
			// failed reads and samples past the count limit leave sum and count alone
			if (!req.read_error && good_cnt < wrcm_pkg::CountLimit) begin
				if (req.current_sample[wrcm_pkg::SampleW-1])
					mag = 17'h10000 - {1'b0, req.current_sample};
				else
					mag = {1'b0, req.current_sample};
				sq = mag * mag;
				sum_wide = {22'd0, sq_sum} + sq;
				// saturating sum, unreachable with a 12 bit count
				if (sum_wide > SumCeil)
					sq_sum = '1;
				else
					sq_sum = sum_wide[wrcm_pkg::SumW-1:0];
				good_cnt++;
			end
		end else begin
			// a zero window length behaves as one tick
			len = (win_len == '0) ? wrcm_pkg::TickW'(1) : win_len;
			if (tick_cnt != '1)
				tick_cnt++;
			if (tick_cnt >= len) begin
				// an empty window reports zero
				if (good_cnt == '0)
					held_rms = '0;
				else
					held_rms = int_sqrt({22'd0, sq_sum} / {52'd0, good_cnt});
				held_cnt = good_cnt;
				sq_sum = '0;
				good_cnt = '0;
				tick_cnt = '0;
				rd.window_done = 1'b1;
			end
		end
		rd.rms_value = held_rms;
		rd.window_samples = held_cnt;
	endtask

	// monitor: model update on each accepted request, check on each accepted result
	always @(posedge clk) begin
		meter_reading_t want;
		meter_reading_t got;
		cycle_cnt++;
		req_accepted <= arst_n && sample_in.valid && sample_in.ready;
		if (arst_n) begin
			if (cfg_wr_en)
				win_len = cfg_wr_data;
			// results first, so a stray result is never matched against this edge's request
			if (result_out.valid && result_out.ready) begin
				got.rms_value = result_out.rms_value;
				got.window_samples = result_out.window_samples;
				got.window_done = result_out.window_done;
				if (expected_readings.size() == 0) begin
					$error("result with no request waiting: rms_value %0d, window_samples %0d",
						got.rms_value, got.window_samples);
					fail_cnt++;
				end else begin
					want = expected_readings.pop_front();
					if (got.rms_value !== want.rms_value) begin
						$error("rms_value: expected %0d, actual %0d",
							want.rms_value, got.rms_value);
						fail_cnt++;
					end
					if (got.window_samples !== want.window_samples) begin
						$error("window_samples: expected %0d, actual %0d",
							want.window_samples, got.window_samples);
						fail_cnt++;
					end
					if (got.window_done !== want.window_done) begin
						$error("window_done: expected %0d, actual %0d",
							want.window_done, got.window_done);
						fail_cnt++;
					end
				end
			end
			if (sample_in.valid && sample_in.ready) begin
				rms_meter_step('{command: sample_in.command,
					current_sample: sample_in.current_sample,
					read_error: sample_in.read_error}, want);
				expected_readings.push_back(want);
				reqs_taken++;
			end
		end
	end

	// driver: a request stays up until taken, then the next one, or a random gap
	always @(negedge clk) begin
		meter_req_t nxt;
		if (arst_n) begin
			if (!sample_in.valid || req_accepted) begin
				if (pending_reqs.size() != 0 && (steady || $urandom_range(99) >= IdlePct)) begin
					nxt = pending_reqs.pop_front();
					sample_in.valid <= 1'b1;
					sample_in.command <= nxt.command;
					sample_in.current_sample <= nxt.current_sample;
					sample_in.read_error <= nxt.read_error;
				end else begin
					sample_in.valid <= 1'b0;
				end
			end
			// result side stalls at random too
			result_out.ready <= steady || ($urandom_range(99) >= IdlePct);
		end
	end

	task automatic push_req(input logic cmd, input logic [wrcm_pkg::SampleW-1:0] smp,
		input logic err);
		pending_reqs.push_back('{command: cmd, current_sample: smp, read_error: err});
		reqs_queued++;
	endtask

	// sample values lean on the extremes and on values near zero
	function automatic logic [wrcm_pkg::SampleW-1:0] random_sample();
		case ($urandom_range(9))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return wrcm_pkg::SampleW'(int'($urandom_range(15)) - 8);
			default: return wrcm_pkg::SampleW'($urandom);
		endcase
	endfunction

	task automatic queue_mixed(input int unsigned n, input int unsigned tick_pct,
		input int unsigned err_pct);
		for (int unsigned k = 0; k < n; k++) begin
			if ($urandom_range(99) < tick_pct)
				push_req(wrcm_pkg::CmdTick, random_sample(), 1'($urandom_range(1)));
			else
				push_req(wrcm_pkg::CmdSample, random_sample(), $urandom_range(99) < err_pct);
		end
	endtask

	// sender holds off until every request has been answered
	task automatic wait_drained();
		while (pending_reqs.size() != 0 || reqs_taken != reqs_queued ||
			expected_readings.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// window length is only changed while the meter sits idle
	task automatic write_window(input logic [wrcm_pkg::TickW-1:0] ticks);
		wait_drained();
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= ticks;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// timeout guard
	initial begin
		while (cycle_cnt < CycleLimit)
			@(posedge clk);
		$display("windowed_rms_current_meter_unit_tb: FAIL");
		$finish;
	end

	initial begin
		// every input known from time zero
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		sample_in.valid = 1'b0;
		sample_in.command = wrcm_pkg::CmdSample;
		sample_in.current_sample = '0;
		sample_in.read_error = 1'b0;
		result_out.ready = 1'b0;
		steady = 1'b0;
		req_accepted = 1'b0;
		reqs_queued = 0;
		reqs_taken = 0;
		fail_cnt = 0;
		cycle_cnt = 0;
		// model comes up in its reset state
		win_len = wrcm_pkg::WindowTicksReset;
		sq_sum = '0;
		good_cnt = '0;
		tick_cnt = '0;
		held_rms = '0;
		held_cnt = '0;

		repeat (ResetCycles) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset window length, extremes, a failed read, a tick that closes nothing
		push_req(wrcm_pkg::CmdSample, 16'h7fff, 1'b0);
		push_req(wrcm_pkg::CmdSample, 16'h8000, 1'b0);
		push_req(wrcm_pkg::CmdSample, 16'h1234, 1'b1);
		push_req(wrcm_pkg::CmdTick, 16'hffff, 1'b1);
		push_req(wrcm_pkg::CmdSample, 16'hffff, 1'b0);

		// zero length acts as one, so every tick closes a window
		write_window(16'd0);
		push_req(wrcm_pkg::CmdTick, 16'h0000, 1'b0);
		// empty window reports zero
		push_req(wrcm_pkg::CmdTick, 16'h8000, 1'b0);
		// most negative reading gives the largest rms
		push_req(wrcm_pkg::CmdSample, 16'h8000, 1'b0);
		push_req(wrcm_pkg::CmdTick, 16'h5a5a, 1'b1);
		push_req(wrcm_pkg::CmdSample, 16'h0000, 1'b0);
		push_req(wrcm_pkg::CmdTick, 16'h0000, 1'b0);
		// only failed reads, so the window is empty
		push_req(wrcm_pkg::CmdSample, 16'h0005, 1'b1);
		push_req(wrcm_pkg::CmdTick, 16'h0000, 1'b0);
		// mean square truncates
		push_req(wrcm_pkg::CmdSample, 16'h0001, 1'b0);
		push_req(wrcm_pkg::CmdSample, 16'h0002, 1'b0);
		push_req(wrcm_pkg::CmdTick, 16'h0000, 1'b0);

		// two tick window: middle tick holds the last values
		write_window(16'd2);
		push_req(wrcm_pkg::CmdSample, 16'h0003, 1'b0);
		push_req(wrcm_pkg::CmdTick, 16'h0000, 1'b0);
		push_req(wrcm_pkg::CmdSample, 16'hfffc, 1'b0);
		push_req(wrcm_pkg::CmdTick, 16'h7fff, 1'b1);
		push_req(wrcm_pkg::CmdTick, 16'h0000, 1'b0);
		push_req(wrcm_pkg::CmdTick, 16'h0000, 1'b0);

		// random phases over several window lengths
		queue_mixed(250, 30, 15);
		write_window(16'd1);
		queue_mixed(100, 40, 15);
		// pause the sender mid-phase until the meter has answered everything
		wait_drained();
		queue_mixed(100, 40, 15);
		write_window(16'd7);
		queue_mixed(250, 20, 10);
		write_window(wrcm_pkg::WindowTicksReset);
		queue_mixed(250, 55, 10);
		write_window(16'd13);
		queue_mixed(150, 15, 25);

		// timer runs past a window length written later, so the next tick closes
		write_window(16'hffff);
		for (int k = 0; k < 100; k++) begin
			push_req(wrcm_pkg::CmdTick, random_sample(), 1'($urandom_range(1)));
			if (k % 10 == 0)
				push_req(wrcm_pkg::CmdSample, random_sample(), 1'b0);
		end
		write_window(16'd5);
		push_req(wrcm_pkg::CmdTick, random_sample(), 1'b0);
		queue_mixed(60, 30, 10);

		// long stretch with no idling on either side
		write_window(16'd3);
		steady = 1'b1;
		queue_mixed(150, 25, 15);
		wait_drained();
		steady = 1'b0;

		// wait out the tail, then report
		wait_drained();
		repeat (SettleCycles) @(posedge clk);
		if (fail_cnt == 0)
			$display("windowed_rms_current_meter_unit_tb: PASS");
		else
			$display("windowed_rms_current_meter_unit_tb: FAIL");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+rtl
rtl/wrcm_pkg.sv
rtl/wrcm_if.sv
rtl/wrcm_alu.sv
rtl/windowed_rms_current_meter_unit.sv
rtl/wrcm_checker.sv
tb/sv/windowed_rms_current_meter_unit_tb.sv
